// ===== hw/rtl/scs1kd_pkg.sv =====
// Shared types, scan code constants and key table of the set-1 scan code decoder.
package scs1kd_pkg;

    localparam int DEFAULT_SCREEN_COLS = 80;
    localparam int DEFAULT_SCREEN_ROWS = 25;

    // Cursor field width and a row index wide enough for the tallest screen.
    localparam int POS_W       = 11;
    localparam int ROW_FIELD_W = 6;
    localparam int CHAR_W      = 7;
    localparam int PAGE_ROWS   = 5;

    localparam logic [7:0] SC_PREFIX     = 8'hE0;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CTRL       = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_ALT        = 8'h38;
    localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [7:0] SC_TABLE_END  = 8'h3B;
    localparam logic [7:0] SC_UP         = 8'h48;
    localparam logic [7:0] SC_DOWN       = 8'h50;
    localparam logic [7:0] SC_LEFT       = 8'h4B;
    localparam logic [7:0] SC_RIGHT      = 8'h4D;
    localparam logic [7:0] SC_HOME       = 8'h47;
    localparam logic [7:0] SC_END        = 8'h4F;
    localparam logic [7:0] SC_PGUP       = 8'h49;
    localparam logic [7:0] SC_PGDN       = 8'h51;
    localparam logic [7:0] SC_DEL        = 8'h53;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CHAR,
        OP_MOVE,
        OP_HOME,
        OP_END,
        OP_BLANK
    } op_t;

    typedef struct packed {
        logic [7:0]       scan_byte;
        logic [POS_W-1:0] cursor_now;
        logic             sink_full;
    } in_item_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
        logic              cursor_write;
        logic [POS_W-1:0]  cursor_next;
        logic              blank_cell;
        logic              ctrl_held;
        logic              alt_held;
    } out_item_t;

    // Decoded beat handed from the decode stage to the output stage.
    typedef struct packed {
        op_t                    op;
        logic [CHAR_W-1:0]      char_code;
        logic [POS_W-1:0]       cursor_next;
        logic [ROW_FIELD_W-1:0] row;
        logic                   ctrl_held;
        logic                   alt_held;
    } dec_t;

    function automatic logic is_letter(input logic [5:0] idx);
        logic res;
        res = ((idx >= 6'h10) && (idx <= 6'h19)) ||
              ((idx >= 6'h1E) && (idx <= 6'h26)) ||
              ((idx >= 6'h2C) && (idx <= 6'h32));
        return res;
    endfunction

    // Returns the shifted or plain ASCII code of a make code below the table end.
    function automatic logic [CHAR_W-1:0] key_char(input logic [5:0] idx, input logic sh);
        logic [2*CHAR_W-1:0] pair;
        unique case (idx)
            6'h01: pair = {7'h1B, 7'h1B};
            6'h02: pair = {7'h21, 7'h31};
            6'h03: pair = {7'h40, 7'h32};
            6'h04: pair = {7'h23, 7'h33};
            6'h05: pair = {7'h24, 7'h34};
            6'h06: pair = {7'h25, 7'h35};
            6'h07: pair = {7'h5E, 7'h36};
            6'h08: pair = {7'h26, 7'h37};
            6'h09: pair = {7'h2A, 7'h38};
            6'h0A: pair = {7'h28, 7'h39};
            6'h0B: pair = {7'h29, 7'h30};
            6'h0C: pair = {7'h5F, 7'h2D};
            6'h0D: pair = {7'h2B, 7'h3D};
            6'h0E: pair = {7'h08, 7'h08};
            6'h0F: pair = {7'h09, 7'h09};
            6'h10: pair = {7'h51, 7'h71};
            6'h11: pair = {7'h57, 7'h77};
            6'h12: pair = {7'h45, 7'h65};
            6'h13: pair = {7'h52, 7'h72};
            6'h14: pair = {7'h54, 7'h74};
            6'h15: pair = {7'h59, 7'h79};
            6'h16: pair = {7'h55, 7'h75};
            6'h17: pair = {7'h49, 7'h69};
            6'h18: pair = {7'h4F, 7'h6F};
            6'h19: pair = {7'h50, 7'h70};
            6'h1A: pair = {7'h7B, 7'h5B};
            6'h1B: pair = {7'h7D, 7'h5D};
            6'h1C: pair = {7'h0A, 7'h0A};
            6'h1E: pair = {7'h41, 7'h61};
            6'h1F: pair = {7'h53, 7'h73};
            6'h20: pair = {7'h44, 7'h64};
            6'h21: pair = {7'h46, 7'h66};
            6'h22: pair = {7'h47, 7'h67};
            6'h23: pair = {7'h48, 7'h68};
            6'h24: pair = {7'h4A, 7'h6A};
            6'h25: pair = {7'h4B, 7'h6B};
            6'h26: pair = {7'h4C, 7'h6C};
            6'h27: pair = {7'h3A, 7'h3B};
            6'h28: pair = {7'h22, 7'h27};
            6'h29: pair = {7'h7E, 7'h60};
            6'h2B: pair = {7'h7C, 7'h5C};
            6'h2C: pair = {7'h5A, 7'h7A};
            6'h2D: pair = {7'h58, 7'h78};
            6'h2E: pair = {7'h43, 7'h63};
            6'h2F: pair = {7'h56, 7'h76};
            6'h30: pair = {7'h42, 7'h62};
            6'h31: pair = {7'h4E, 7'h6E};
            6'h32: pair = {7'h4D, 7'h6D};
            6'h33: pair = {7'h3C, 7'h2C};
            6'h34: pair = {7'h3E, 7'h2E};
            6'h35: pair = {7'h3F, 7'h2F};
            6'h37: pair = {7'h2A, 7'h2A};
            6'h39: pair = {7'h20, 7'h20};
            default: pair = '0;
        endcase
        return sh ? pair[2*CHAR_W-1:CHAR_W] : pair[CHAR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/scs1kd_stream_if.sv =====
// Valid/ready channel carrying one payload beat per handshake.
interface scs1kd_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/scs1kd_decode.sv =====
// Input register, modifier state and decode stage with the row quotient.
module scs1kd_decode #(
    parameter int SCREEN_COLS = scs1kd_pkg::DEFAULT_SCREEN_COLS,
    parameter int SCREEN_ROWS = scs1kd_pkg::DEFAULT_SCREEN_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    scs1kd_stream_if.sink          scan,
    scs1kd_stream_if.source        dec
);

    localparam int POS_W  = scs1kd_pkg::POS_W;
    localparam int ROW_W  = scs1kd_pkg::ROW_FIELD_W;
    localparam int TOTAL  = SCREEN_COLS * SCREEN_ROWS;
    localparam int W      = $clog2(TOTAL) + 1;
    localparam int PAGE   = scs1kd_pkg::PAGE_ROWS * SCREEN_COLS;
    // Reciprocal rounded up; exact for every cursor value below 2**POS_W.
    localparam int DIV_SHIFT = POS_W + $clog2(SCREEN_COLS);
    localparam int RECIP     = ((1 << DIV_SHIFT) + SCREEN_COLS - 1) / SCREEN_COLS;
    localparam int PROD_W    = DIV_SHIFT + ROW_W + 1;

    localparam logic [W-1:0] LAST_C       = W'(TOTAL - 1);
    localparam logic [W-1:0] COLS_C       = W'(SCREEN_COLS);
    localparam logic [W-1:0] PAGE_C       = W'(PAGE);
    localparam logic [W-1:0] DOWN_LIMIT_C = W'(TOTAL - SCREEN_COLS);
    localparam logic [W-1:0] PGDN_LIMIT_C = W'(TOTAL - PAGE);

    logic                   a_valid_reg;
    scs1kd_pkg::in_item_t   a_item_reg;
    logic                   b_valid_reg;
    scs1kd_pkg::dec_t       b_dec_reg;
    scs1kd_pkg::dec_t       b_dec_next;

    logic prefix_reg, prefix_next;
    logic shift_reg,  shift_next;
    logic ctrl_reg,   ctrl_next;
    logic alt_reg,    alt_next;
    logic caps_reg,   caps_next;

    logic                           a_take;
    logic                           b_take;
    logic                           b_load;
    logic [7:0]                     code;
    logic [POS_W-1:0]               sat_pos;
    logic [W-1:0]                   pos_w;
    logic [PROD_W-1:0]              quot_prod;
    logic [scs1kd_pkg::CHAR_W-1:0]  ch;

    assign b_take    = !b_valid_reg || dec.ready;
    assign b_load    = a_valid_reg && b_take;
    assign a_take    = !a_valid_reg || b_take;
    assign scan.ready = a_take;

    assign dec.valid   = b_valid_reg;
    assign dec.payload = b_dec_reg;

    assign code    = a_item_reg.scan_byte;
    assign sat_pos = (W'(a_item_reg.cursor_now) > LAST_C) ? POS_W'(TOTAL - 1)
                                                          : a_item_reg.cursor_now;
    assign pos_w   = W'(sat_pos);

    assign quot_prod = PROD_W'(sat_pos) * PROD_W'(RECIP);

    always_comb
    begin
        prefix_next = prefix_reg;
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        caps_next   = caps_reg;
        ch          = '0;
        b_dec_next  = '0;
        b_dec_next.op  = scs1kd_pkg::OP_NONE;
        b_dec_next.row = quot_prod[DIV_SHIFT +: ROW_W];

        if (code == scs1kd_pkg::SC_PREFIX)
        begin
            prefix_next = 1'b1;
        end
        else
        begin
            prefix_next = 1'b0;
            if (!prefix_reg && (code == scs1kd_pkg::SC_LSHIFT ||
                                code == scs1kd_pkg::SC_RSHIFT))
            begin
                shift_next = 1'b1;
            end
            else if (!prefix_reg && (code == scs1kd_pkg::SC_LSHIFT_BRK ||
                                     code == scs1kd_pkg::SC_RSHIFT_BRK))
            begin
                shift_next = 1'b0;
            end
            else if (code == scs1kd_pkg::SC_CTRL)
            begin
                ctrl_next = 1'b1;
            end
            else if (code == scs1kd_pkg::SC_CTRL_BRK)
            begin
                ctrl_next = 1'b0;
            end
            else if (code == scs1kd_pkg::SC_ALT)
            begin
                alt_next = 1'b1;
            end
            else if (code == scs1kd_pkg::SC_ALT_BRK)
            begin
                alt_next = 1'b0;
            end
            else if (!prefix_reg && code == scs1kd_pkg::SC_CAPS)
            begin
                caps_next = !caps_reg;
            end
            else if (code[7])
            begin
                // Any other break code leaves the result empty.
                b_dec_next.op = scs1kd_pkg::OP_NONE;
            end
            else if (prefix_reg)
            begin
                unique case (code)
                    scs1kd_pkg::SC_UP:
                    begin
                        if (pos_w >= COLS_C)
                        begin
                            b_dec_next.op          = scs1kd_pkg::OP_MOVE;
                            b_dec_next.cursor_next = POS_W'(pos_w - COLS_C);
                        end
                    end
                    scs1kd_pkg::SC_DOWN:
                    begin
                        if (pos_w < DOWN_LIMIT_C)
                        begin
                            b_dec_next.op          = scs1kd_pkg::OP_MOVE;
                            b_dec_next.cursor_next = POS_W'(pos_w + COLS_C);
                        end
                    end
                    scs1kd_pkg::SC_LEFT:
                    begin
                        if (pos_w != '0)
                        begin
                            b_dec_next.op          = scs1kd_pkg::OP_MOVE;
                            b_dec_next.cursor_next = POS_W'(pos_w - W'(1));
                        end
                    end
                    scs1kd_pkg::SC_RIGHT:
                    begin
                        if (pos_w < LAST_C)
                        begin
                            b_dec_next.op          = scs1kd_pkg::OP_MOVE;
                            b_dec_next.cursor_next = POS_W'(pos_w + W'(1));
                        end
                    end
                    scs1kd_pkg::SC_HOME:
                    begin
                        b_dec_next.op = scs1kd_pkg::OP_HOME;
                    end
                    scs1kd_pkg::SC_END:
                    begin
                        b_dec_next.op = scs1kd_pkg::OP_END;
                    end
                    scs1kd_pkg::SC_PGUP:
                    begin
                        b_dec_next.op          = scs1kd_pkg::OP_MOVE;
                        b_dec_next.cursor_next = (pos_w >= PAGE_C) ? POS_W'(pos_w - PAGE_C)
                                                                   : '0;
                    end
                    scs1kd_pkg::SC_PGDN:
                    begin
                        if (pos_w < PGDN_LIMIT_C)
                        begin
                            b_dec_next.op          = scs1kd_pkg::OP_MOVE;
                            b_dec_next.cursor_next = POS_W'(pos_w + PAGE_C);
                        end
                    end
                    scs1kd_pkg::SC_DEL:
                    begin
                        b_dec_next.op = scs1kd_pkg::OP_BLANK;
                    end
                    default:
                    begin
                        b_dec_next.op = scs1kd_pkg::OP_NONE;
                    end
                endcase
            end
            else if (code < scs1kd_pkg::SC_TABLE_END)
            begin
                // Caps lock flips shift for letter keys only.
                ch = scs1kd_pkg::key_char(code[5:0],
                         shift_reg ^ (caps_reg & scs1kd_pkg::is_letter(code[5:0])));
                if (ch != '0 && !a_item_reg.sink_full)
                begin
                    b_dec_next.op        = scs1kd_pkg::OP_CHAR;
                    b_dec_next.char_code = ch;
                end
            end
        end

        b_dec_next.ctrl_held = ctrl_next;
        b_dec_next.alt_held  = alt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            prefix_reg  <= 1'b0;
            shift_reg   <= 1'b0;
            ctrl_reg    <= 1'b0;
            alt_reg     <= 1'b0;
            caps_reg    <= 1'b0;
        end
        else
        begin
            if (a_take)
            begin
                a_valid_reg <= scan.valid;
            end
            if (b_take)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (b_load)
            begin
                prefix_reg <= prefix_next;
                shift_reg  <= shift_next;
                ctrl_reg   <= ctrl_next;
                alt_reg    <= alt_next;
                caps_reg   <= caps_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take && scan.valid)
        begin
            a_item_reg <= scan.payload;
        end
        if (b_load)
        begin
            b_dec_reg <= b_dec_next;
        end
    end

endmodule

// ===== hw/rtl/scs1kd_place.sv =====
// Output stage: forms the result beat and works out row start and row end.
module scs1kd_place #(
    parameter int SCREEN_COLS = scs1kd_pkg::DEFAULT_SCREEN_COLS
) (
    input  logic              clk,
    input  logic              rst_n,
    scs1kd_stream_if.sink     dec,
    scs1kd_stream_if.source   result
);

    localparam int POS_W  = scs1kd_pkg::POS_W;
    localparam int ROW_W  = scs1kd_pkg::ROW_FIELD_W;
    localparam int PROD_W = ROW_W + $clog2(SCREEN_COLS + 1);

    logic                  c_valid_reg;
    scs1kd_pkg::out_item_t c_item_reg;
    scs1kd_pkg::out_item_t c_item_next;
    logic                  c_take;
    logic [PROD_W-1:0]     row_start;
    logic [PROD_W-1:0]     row_end;

    assign c_take         = !c_valid_reg || result.ready;
    assign dec.ready      = c_take;
    assign result.valid   = c_valid_reg;
    assign result.payload = c_item_reg;

    assign row_start = PROD_W'(dec.payload.row) * PROD_W'(SCREEN_COLS);
    assign row_end   = row_start + PROD_W'(SCREEN_COLS - 1);

    always_comb
    begin
        c_item_next           = '0;
        c_item_next.ctrl_held = dec.payload.ctrl_held;
        c_item_next.alt_held  = dec.payload.alt_held;
        case (dec.payload.op)
            scs1kd_pkg::OP_CHAR:
            begin
                c_item_next.char_valid = 1'b1;
                c_item_next.char_code  = dec.payload.char_code;
            end
            scs1kd_pkg::OP_MOVE:
            begin
                c_item_next.cursor_write = 1'b1;
                c_item_next.cursor_next  = dec.payload.cursor_next;
            end
            scs1kd_pkg::OP_HOME:
            begin
                c_item_next.cursor_write = 1'b1;
                c_item_next.cursor_next  = POS_W'(row_start);
            end
            scs1kd_pkg::OP_END:
            begin
                c_item_next.cursor_write = 1'b1;
                c_item_next.cursor_next  = POS_W'(row_end);
            end
            scs1kd_pkg::OP_BLANK:
            begin
                c_item_next.blank_cell = 1'b1;
            end
            default:
            begin
                c_item_next.char_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_take)
        begin
            c_valid_reg <= dec.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_take && dec.valid)
        begin
            c_item_reg <= c_item_next;
        end
    end

endmodule

// ===== hw/rtl/scancode_set1_keyboard_decoder_top.sv =====
// Throughput: one scan byte per cycle while result.ready stays high; three
// register stages (input, decode with the row-quotient multiplier, output with
// the row-start multiplier) each take a new beat whenever they are empty or are
// handing their beat on.
// Reset clears all valid flags, the prefix flag, the modifiers and caps lock.
// Top level of the set-1 scan code decoder.
module scancode_set1_keyboard_decoder_top #(
    parameter int SCREEN_COLS = scs1kd_pkg::DEFAULT_SCREEN_COLS,
    parameter int SCREEN_ROWS = scs1kd_pkg::DEFAULT_SCREEN_ROWS
) (
    input  logic              clk,
    input  logic              rst_n,
    scs1kd_stream_if.sink     scan,
    scs1kd_stream_if.source   result
);

    localparam int TOTAL = SCREEN_COLS * SCREEN_ROWS;
    localparam int W     = $clog2(TOTAL) + 1;

    scs1kd_stream_if #(.payload_t(scs1kd_pkg::dec_t)) dec_ch ();

    scs1kd_decode #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan),
        .dec   (dec_ch)
    );

    scs1kd_place #(
        .SCREEN_COLS (SCREEN_COLS)
    ) u_place (
        .clk    (clk),
        .rst_n  (rst_n),
        .dec    (dec_ch),
        .result (result)
    );

    // A result beat does at most one thing.
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> $countones({result.payload.char_valid,
                                     result.payload.cursor_write,
                                     result.payload.blank_cell}) <= 1)
        else $error("result beat carries more than one action");

    // Unused payload fields are zero.
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.payload.char_valid || result.payload.char_code == '0) &&
                          (result.payload.cursor_write || result.payload.cursor_next == '0)))
        else $error("unused result field is not zero");

    // A cursor move never leaves the screen.
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.cursor_write) |->
            (W'(result.payload.cursor_next) < W'(TOTAL)))
        else $error("cursor move off the screen");

    // A decoded character beat always carries a nonzero table entry.
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_ch.valid && dec_ch.payload.op == scs1kd_pkg::OP_CHAR) |->
            (dec_ch.payload.char_code != '0))
        else $error("character beat with empty code");

endmodule

// ===== test/scs1kd_checker.sv =====
// Scoreboard for the set-1 scan code decoder: predicts each result beat and compares it.
module scs1kd_checker #(
    parameter int COLS = scs1kd_pkg::DEFAULT_SCREEN_COLS,
    parameter int ROWS = scs1kd_pkg::DEFAULT_SCREEN_ROWS
) (
    input  logic      clk,
    input  logic      rst_n,
    scs1kd_stream_if  scan,
    scs1kd_stream_if  result,
    output int        mismatches,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import scs1kd_pkg::*;

    localparam logic [7:0] BREAK_BIT = 8'h80;
    localparam int         MAX_SHOWN = 10;

    localparam logic [CHAR_W-1:0] PLAIN_KEYS [0:58] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00
    };

    localparam logic [CHAR_W-1:0] SHIFTED_KEYS [0:58] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00
    };

    logic      prefix_seen;
    logic      shift_down;
    logic      ctrl_down;
    logic      alt_down;
    logic      caps_on;
    out_item_t key_results_q [$];
    int        miss_cnt;

    function automatic logic key_is_letter(input logic [7:0] key);
        return (key >= 8'h10 && key <= 8'h19) || (key >= 8'h1E && key <= 8'h26) ||
               (key >= 8'h2C && key <= 8'h32);
    endfunction

    // Advances the keyboard state by one byte and returns the result it gives.
    function automatic out_item_t decode_scan(input in_item_t beat);
        out_item_t        res;
        int               pos;
        int               total;
        int               target;
        logic             ext;
        logic             sh;
        logic [7:0]       key;
        logic [CHAR_W-1:0] ch;
        res    = '0;
        total  = COLS * ROWS;
        target = -1;
        key    = beat.scan_byte;
        pos    = int'(beat.cursor_now);
        if (pos > total - 1)
            pos = total - 1;
        if (key == SC_PREFIX)
            prefix_seen = 1'b1;
        else
        begin
            ext = prefix_seen;
            prefix_seen = 1'b0;
            if (!ext && (key == SC_LSHIFT || key == SC_RSHIFT))
                shift_down = 1'b1;
            else if (!ext && (key == SC_LSHIFT_BRK || key == SC_RSHIFT_BRK))
                shift_down = 1'b0;
            else if (key == SC_CTRL)
                ctrl_down = 1'b1;
            else if (key == SC_CTRL_BRK)
                ctrl_down = 1'b0;
            else if (key == SC_ALT)
                alt_down = 1'b1;
            else if (key == SC_ALT_BRK)
                alt_down = 1'b0;
            else if (!ext && key == SC_CAPS)
                caps_on = !caps_on;
            else if ((key & BREAK_BIT) != 0)
            begin
                // Any remaining release code is silent.
            end
            else if (ext)
            begin
                case (key)
                    SC_UP:    if (pos >= COLS) target = pos - COLS;
                    SC_DOWN:  if (pos < total - COLS) target = pos + COLS;
                    SC_LEFT:  if (pos > 0) target = pos - 1;
                    SC_RIGHT: if (pos < total - 1) target = pos + 1;
                    SC_HOME:  target = (pos / COLS) * COLS;
                    SC_END:   target = (pos / COLS) * COLS + COLS - 1;
                    SC_PGUP:  target = (pos >= PAGE_ROWS * COLS) ? pos - PAGE_ROWS * COLS : 0;
                    SC_PGDN:  if (pos < total - PAGE_ROWS * COLS) target = pos + PAGE_ROWS * COLS;
                    SC_DEL:   res.blank_cell = 1'b1;
                    default:  ;
                endcase
            end
            else if (key < SC_TABLE_END)
            begin
                sh = shift_down ^ (caps_on && key_is_letter(key));
                ch = sh ? SHIFTED_KEYS[key] : PLAIN_KEYS[key];
                if (ch != '0 && !beat.sink_full)
                begin
                    res.char_valid = 1'b1;
                    res.char_code  = ch;
                end
            end
        end
        if (target >= 0)
        begin
            res.cursor_write = 1'b1;
            res.cursor_next  = target[POS_W-1:0];
        end
        res.ctrl_held = ctrl_down;
        res.alt_held  = alt_down;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input out_item_t want, input out_item_t got);
        miss_cnt++;
        if (miss_cnt <= MAX_SHOWN)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected cv=%0b ch=%h cw=%0b nxt=%0d blank=%0b ctrl=%0b alt=%0b",
                     want.char_valid, want.char_code, want.cursor_write, want.cursor_next,
                     want.blank_cell, want.ctrl_held, want.alt_held);
            $display("  actual   cv=%0b ch=%h cw=%0b nxt=%0d blank=%0b ctrl=%0b alt=%0b",
                     got.char_valid, got.char_code, got.cursor_write, got.cursor_next,
                     got.blank_cell, got.ctrl_held, got.alt_held);
        end
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (key_results_q.size() == 0)
        begin
            report_mismatch("result beat with nothing expected", '0, got);
            return;
        end
        want = key_results_q.pop_front();
        if (got.char_valid !== want.char_valid || got.char_code !== want.char_code ||
            got.cursor_write !== want.cursor_write || got.cursor_next !== want.cursor_next ||
            got.blank_cell !== want.blank_cell || got.ctrl_held !== want.ctrl_held ||
            got.alt_held !== want.alt_held)
            report_mismatch("result beat differs", want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_seen = 1'b0;
            shift_down  = 1'b0;
            ctrl_down   = 1'b0;
            alt_down    = 1'b0;
            caps_on     = 1'b0;
            key_results_q.delete();
            miss_cnt    = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (scan.valid && scan.ready)
                key_results_q.push_back(decode_scan(scan.payload));
            if (result.valid && result.ready)
                compare_result(result.payload);
            mismatches <= miss_cnt;
            pending    <= key_results_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the scan code decoder testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scs1kd_pkg::*;

    localparam logic [7:0] BREAK_BIT  = 8'h80;
    localparam int         HOLD_TIME  = 64;
    localparam int         PHASE_LEN  = 256;

    localparam logic [7:0] NAV_KEYS [0:8] = '{
        SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME, SC_END, SC_PGUP, SC_PGDN, SC_DEL
    };
    localparam logic [7:0] MOD_KEYS [0:3] = '{SC_LSHIFT, SC_RSHIFT, SC_CTRL, SC_ALT};
    localparam int         SRC_IDLE [0:3] = '{0, 51, 0, 13};
    localparam int         SINK_STALL [0:3] = '{0, 0, 51, 13};

    logic clk;
    logic rst_n;
    logic hold_req;
    logic hold_off;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   sent;
    int   mismatches;
    int   pending;

    scs1kd_stream_if #(.payload_t(in_item_t))  scan_ch ();
    scs1kd_stream_if #(.payload_t(out_item_t)) result_ch ();

    scancode_set1_keyboard_decoder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan_ch),
        .result (result_ch)
    );

    scs1kd_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
        result_ch.ready <= !hold_off && ($urandom_range(0, 99) >= sink_stall_pct);

    // Long receiver hold-off so that the pipeline fills and the input stalls.
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_TIME) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [POS_W-1:0] random_cursor();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return POS_W'(0);
        else if (pick < 12)
            return POS_W'(1999);
        else if (pick < 16)
            return POS_W'($urandom_range(0, 1) ? 79 : 1920);
        else if (pick < 22)
            return POS_W'($urandom_range(2000, 2047));
        return POS_W'($urandom_range(0, 1999));
    endfunction

    function automatic logic full_flag();
        return $urandom_range(0, 4) == 0;
    endfunction

    // Offers one beat, with random idle cycles in front, and returns at the falling edge.
    task automatic send_scan(input logic [7:0] key, input logic [POS_W-1:0] pos,
                             input logic full);
        in_item_t beat;
        beat.scan_byte  = key;
        beat.cursor_now = pos;
        beat.sink_full  = full;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            scan_ch.valid <= 1'b0;
            @(negedge clk);
        end
        scan_ch.valid   <= 1'b1;
        scan_ch.payload <= beat;
        do
            @(posedge clk);
        while (!scan_ch.ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_extended(input logic [7:0] key, input logic [POS_W-1:0] pos,
                                 input logic full);
        send_scan(SC_PREFIX, random_cursor(), full_flag());
        send_scan(key, pos, full);
    endtask

    task automatic random_stroke();
        int         pick;
        logic [7:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_scan(8'($urandom_range(0, 58)), random_cursor(), full_flag());
        else if (pick < 55)
            send_extended(NAV_KEYS[$urandom_range(0, 8)], random_cursor(), full_flag());
        else if (pick < 67)
        begin
            key = MOD_KEYS[$urandom_range(0, 3)];
            if ($urandom_range(0, 1))
                key = key | BREAK_BIT;
            if ($urandom_range(0, 3) == 0)
                send_extended(key, random_cursor(), full_flag());
            else
                send_scan(key, random_cursor(), full_flag());
        end
        else if (pick < 72)
            send_scan(SC_CAPS, random_cursor(), full_flag());
        else if (pick < 82)
            send_scan(8'($urandom_range(0, 58)) | BREAK_BIT, random_cursor(), full_flag());
        else if (pick < 92)
            send_scan(8'($urandom_range(0, 255)), random_cursor(), full_flag());
        else
            send_extended(8'($urandom_range(0, 255)), random_cursor(), full_flag());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        hold_req        = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        sent            = 0;
        scan_ch.valid   = 1'b0;
        scan_ch.payload = '0;
        result_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: table extremes, modifiers, caps on letters only, full buffer,
        // refused moves at the screen edges, saturated cursor and repeated prefix.
        send_scan(8'h00, POS_W'(0), 1'b0);
        send_scan(8'hFF, POS_W'(2047), 1'b1);
        send_scan(SC_LSHIFT, POS_W'(0), 1'b0);
        send_scan(8'h1E, POS_W'(0), 1'b0);
        send_scan(SC_CAPS, POS_W'(0), 1'b0);
        send_scan(8'h1E, POS_W'(0), 1'b0);
        send_scan(8'h02, POS_W'(0), 1'b0);
        send_scan(SC_LSHIFT_BRK, POS_W'(0), 1'b0);
        send_scan(8'h10, POS_W'(0), 1'b1);
        send_scan(SC_CTRL, POS_W'(0), 1'b0);
        send_extended(SC_ALT, POS_W'(0), 1'b0);
        send_scan(SC_CTRL_BRK, POS_W'(0), 1'b0);
        send_scan(SC_PREFIX, POS_W'(0), 1'b0);
        send_extended(SC_UP, POS_W'(0), 1'b0);
        send_extended(SC_DOWN, POS_W'(1999), 1'b0);
        send_extended(SC_LEFT, POS_W'(0), 1'b0);
        send_extended(SC_RIGHT, POS_W'(2047), 1'b0);
        send_extended(SC_HOME, POS_W'(2047), 1'b0);
        send_extended(SC_END, POS_W'(0), 1'b0);
        send_extended(SC_PGUP, POS_W'(399), 1'b0);
        send_extended(SC_PGDN, POS_W'(1599), 1'b0);
        send_extended(SC_DEL, POS_W'(1000), 1'b1);
        send_scan(SC_ALT_BRK, POS_W'(0), 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct   = SRC_IDLE[phase];
            sink_stall_pct = SINK_STALL[phase];
            if (phase == 0)
                hold_req = 1'b1;
            while (sent < 25 + (phase + 1) * PHASE_LEN)
                random_stroke();
        end
        scan_ch.valid <= 1'b0;

        while (pending != 0 || result_ch.valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
